// File: design/dq_pkg.sv
`default_nettype none

package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    REQ_PUSH_RIGHT = 2'd0,
    REQ_POP_LEFT   = 2'd1,
    REQ_POP_RIGHT  = 2'd2,
    REQ_PEEK       = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_DONE       = 2'd0,
    ST_POP_EMPTY  = 2'd1,
    ST_PUSH_FULL  = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] item_value;
  } in_t;

  typedef struct packed {
    logic [31:0] removed_value;
    logic [31:0] left_value;
    logic [31:0] right_value;
    logic        is_empty;
    logic [6:0]  item_count;
    logic [1:0]  status;
  } out_t;

endpackage

`default_nettype wire

// File: design/dq_ram.sv
`default_nettype none

module dq_ram #(
  parameter int ADDR_W = 6,
  parameter int DATA_W = 32
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [DATA_W-1:0] wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: design/double_ended_queue.sv
// Bounded deque of DEPTH items on a ring buffer in a single-port-read memory. A request is
// taken when start is high and busy is low; its result appears on out_data for exactly one
// cycle with out_valid high, and the receiver cannot stall it. Pushes, peeks and refused
// requests give their result in the cycle after the beat and a new request may follow
// at once. A pop that leaves items behind holds busy high for one cycle while the
// memory's registered read port fetches the new end item. The ends are also kept in
// registers, so no other request reads the memory. No clearing pass after reset is needed.
`default_nettype none

module double_ended_queue
  import dq_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  state_t state_r, state_nxt;
  logic [ADDR_W-1:0]     left_idx_r, left_idx_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic [DATA_WIDTH-1:0] lval_r, lval_nxt;
  logic [DATA_WIDTH-1:0] rval_r, rval_nxt;
  logic                  pend_left_r, pend_left_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_t                  out_data_r, out_data_nxt;

  logic                  accept;
  logic                  empty, full;
  logic [ADDR_W-1:0]     right_idx, push_idx;
  logic                  ram_we, ram_re, rd_left;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata, item;
  logic [DATA_WIDTH-1:0] removed;
  status_t               stat;

  assign accept = start && !busy;
  assign empty  = (count_r == '0);
  assign full   = (count_r == CNT_W'(DEPTH));
  assign item   = in_data.item_value[DATA_WIDTH-1:0];

  // depth is a power of two, so slot arithmetic wraps on its own
  assign push_idx  = left_idx_r + count_r[ADDR_W-1:0];
  assign right_idx = push_idx - ADDR_W'(1);

  dq_ram #(
    .ADDR_W (ADDR_W),
    .DATA_W (DATA_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (push_idx),
    .wdata (item),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    left_idx_nxt  = left_idx_r;
    count_nxt     = count_r;
    lval_nxt      = lval_r;
    rval_nxt      = rval_r;
    pend_left_nxt = pend_left_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = 1'b0;
    removed       = '0;
    stat          = ST_DONE;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    rd_left       = 1'b1;
    ram_raddr     = left_idx_r + ADDR_W'(1);
    if (accept) begin
      case (req_t'(in_data.req_type))
        REQ_PUSH_RIGHT: begin
          if (full) begin
            stat = ST_PUSH_FULL;
          end else begin
            ram_we    = 1'b1;
            count_nxt = count_r + CNT_W'(1);
            rval_nxt  = item;
            if (empty) begin
              lval_nxt = item;
            end
          end
        end
        REQ_POP_LEFT: begin
          if (empty) begin
            stat = ST_POP_EMPTY;
          end else begin
            removed      = lval_r;
            left_idx_nxt = left_idx_r + ADDR_W'(1);
            count_nxt    = count_r - CNT_W'(1);
            ram_re       = (count_r != CNT_W'(1));
          end
        end
        REQ_POP_RIGHT: begin
          if (empty) begin
            stat = ST_POP_EMPTY;
          end else begin
            removed   = rval_r;
            count_nxt = count_r - CNT_W'(1);
            rd_left   = 1'b0;
            ram_raddr = right_idx - ADDR_W'(1);
            ram_re    = (count_r != CNT_W'(1));
          end
        end
        REQ_PEEK: begin
        end
        default: begin
        end
      endcase
      if (count_nxt == '0) begin
        lval_nxt = '0;
        rval_nxt = '0;
      end
      out_data_nxt.removed_value = 32'(removed);
      out_data_nxt.left_value    = 32'(lval_nxt);
      out_data_nxt.right_value   = 32'(rval_nxt);
      out_data_nxt.is_empty      = (count_nxt == '0);
      out_data_nxt.item_count    = 7'(count_nxt);
      out_data_nxt.status        = stat;
      out_valid_nxt              = !ram_re;
      pend_left_nxt              = rd_left;
    end else if (state_r == S_READ) begin
      // patch the end that the memory has just delivered
      if (pend_left_r) begin
        lval_nxt                = ram_rdata;
        out_data_nxt.left_value = 32'(ram_rdata);
      end else begin
        rval_nxt                 = ram_rdata;
        out_data_nxt.right_value = 32'(ram_rdata);
      end
      out_valid_nxt = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && ram_re) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    busy = (state_r == S_READ);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      left_idx_r  <= '0;
      count_r     <= '0;
      lval_r      <= '0;
      rval_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      left_idx_r  <= left_idx_nxt;
      count_r     <= count_nxt;
      lval_r      <= lval_nxt;
      rval_r      <= rval_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_left_r <= pend_left_nxt;
    out_data_r  <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_beat_answered: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (out_valid ^ busy))
    else $error("accepted beat neither answered nor waiting on memory");

  a_read_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> (!busy && out_valid))
    else $error("memory read wait not exactly one cycle");

  a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_empty == (out_data.item_count == 7'd0)))
    else $error("empty flag disagrees with count");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("item count beyond depth");

endmodule

`default_nettype wire

// File: dv/double_ended_queue_tb.sv
`timescale 1ns / 1ps

module double_ended_queue_tb;
  import dq_pkg::*;

  localparam int RAND_PER_PHASE = 520;
  localparam int SEG_LEN        = 120;
  localparam int CYCLE_LIMIT    = 200000;

  typedef struct {
    req_t        op;
    logic [31:0] value;
    bit          typed;
    out_t        result;
  } dir_row_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  // shadow deque
  logic [DATA_WIDTH-1:0] dq_ring [DEPTH];
  int dq_head;
  int dq_held;

  out_t pending_results [$];
  out_t oldest_result;
  int   errors;
  int   cycles;
  int   beats_sent;
  int   results_checked;
  int   full_refusals;
  int   empty_refusals;

  dir_row_t dir_tbl [24];

  double_ended_queue u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic out_t deque_result(logic [31:0] removed, logic [31:0] left,
                                        logic [31:0] right, logic empty,
                                        logic [6:0] count, status_t st);
    out_t r;
    r.removed_value = removed;
    r.left_value    = left;
    r.right_value   = right;
    r.is_empty      = empty;
    r.item_count    = count;
    r.status        = st;
    return r;
  endfunction

  // advances the shadow deque by one request and returns what the block should report
  function automatic out_t apply_request(in_t req);
    out_t r;
    r = '0;
    r.status = ST_DONE;
    case (req.req_type)
      REQ_PUSH_RIGHT: begin
        if (dq_held == DEPTH) begin
          r.status = ST_PUSH_FULL;
          full_refusals++;
        end else begin
          dq_ring[(dq_head + dq_held) % DEPTH] = req.item_value;
          dq_held++;
        end
      end
      REQ_POP_LEFT, REQ_POP_RIGHT: begin
        if (dq_held == 0) begin
          r.status = ST_POP_EMPTY;
          empty_refusals++;
        end else if (req.req_type == REQ_POP_LEFT) begin
          r.removed_value = dq_ring[dq_head];
          dq_head = (dq_head + 1) % DEPTH;
          dq_held--;
        end else begin
          r.removed_value = dq_ring[(dq_head + dq_held - 1) % DEPTH];
          dq_held--;
        end
      end
      default: ;
    endcase
    if (dq_held != 0) begin
      r.left_value  = dq_ring[dq_head];
      r.right_value = dq_ring[(dq_head + dq_held - 1) % DEPTH];
    end
    r.is_empty   = (dq_held == 0);
    r.item_count = 7'(dq_held);
    return r;
  endfunction

  // mode 0 fills, mode 1 drains, mode 2 wanders
  function automatic req_t pick_request(int mode);
    int r;
    r = $urandom_range(99);
    case (mode)
      0:       return r < 80 ? REQ_PUSH_RIGHT : r < 88 ? REQ_POP_LEFT :
                      r < 96 ? REQ_POP_RIGHT : REQ_PEEK;
      1:       return r < 15 ? REQ_PUSH_RIGHT : r < 55 ? REQ_POP_LEFT :
                      r < 92 ? REQ_POP_RIGHT : REQ_PEEK;
      default: return r < 40 ? REQ_PUSH_RIGHT : r < 65 ? REQ_POP_LEFT :
                      r < 90 ? REQ_POP_RIGHT : REQ_PEEK;
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(7))
      0:       return '1;
      1:       return '0;
      2:       return 32'h1 << $urandom_range(31);
      default: return $urandom;
    endcase
  endfunction

  // start stays high after the beat so back-to-back requests need no extra edge
  task automatic send_request(in_t item, bit typed, out_t typed_result);
    out_t predicted;
    start   <= 1'b1;
    in_data <= item;
    @(posedge clk);
    while (busy) @(posedge clk);
    predicted = apply_request(item);
    if (typed) begin
      predicted = typed_result;
    end
    pending_results.insert(pending_results.size(), predicted);
    beats_sent++;
  endtask

  task automatic maybe_idle(int pct);
    int gap;
    if ($urandom_range(99) < pct) begin
      gap = $urandom_range(1, 3);
      start   <= 1'b0;
      in_data <= in_t'({2'($urandom), $urandom});
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // a pop may still be finishing its read
    repeat (2) @(posedge clk);
  endtask

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result beat with nothing expected, actual %h", $time, out_data);
        errors++;
      end else begin
        oldest_result = pending_results.pop_front();
        results_checked++;
        check_field("removed_value", oldest_result.removed_value, out_data.removed_value);
        check_field("left_value", oldest_result.left_value, out_data.left_value);
        check_field("right_value", oldest_result.right_value, out_data.right_value);
        check_field("is_empty", 32'(oldest_result.is_empty), 32'(out_data.is_empty));
        check_field("item_count", 32'(oldest_result.item_count), 32'(out_data.item_count));
        check_field("status", 32'(oldest_result.status), 32'(out_data.status));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t ns: run did not complete, %0d results outstanding", $time,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    in_t item;
    int  idle_pct [3];
    int  seg;
    errors          = 0;
    cycles          = 0;
    beats_sent      = 0;
    results_checked = 0;
    full_refusals   = 0;
    empty_refusals  = 0;
    dq_head         = 0;
    dq_held         = 0;
    idle_pct        = '{37, 59, 0};
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_data <= '0;

    dir_tbl = '{
      '{REQ_PEEK,       32'h0000_0000, 1'b1,
        deque_result(32'h0, 32'h0, 32'h0, 1'b1, 7'd0, ST_DONE)},
      '{REQ_POP_LEFT,   32'hffff_ffff, 1'b1,
        deque_result(32'h0, 32'h0, 32'h0, 1'b1, 7'd0, ST_POP_EMPTY)},
      '{REQ_POP_RIGHT,  32'h0000_0000, 1'b1,
        deque_result(32'h0, 32'h0, 32'h0, 1'b1, 7'd0, ST_POP_EMPTY)},
      '{REQ_PUSH_RIGHT, 32'hffff_ffff, 1'b1,
        deque_result(32'h0, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 7'd1, ST_DONE)},
      '{REQ_PUSH_RIGHT, 32'h0000_0000, 1'b1,
        deque_result(32'h0, 32'hffff_ffff, 32'h0, 1'b0, 7'd2, ST_DONE)},
      '{REQ_PEEK,       32'h0000_0000, 1'b1,
        deque_result(32'h0, 32'hffff_ffff, 32'h0, 1'b0, 7'd2, ST_DONE)},
      '{REQ_POP_RIGHT,  32'h0000_0000, 1'b1,
        deque_result(32'h0, 32'hffff_ffff, 32'hffff_ffff, 1'b0, 7'd1, ST_DONE)},
      '{REQ_POP_LEFT,   32'h0000_0000, 1'b1,
        deque_result(32'hffff_ffff, 32'h0, 32'h0, 1'b1, 7'd0, ST_DONE)},
      '{REQ_POP_RIGHT,  32'hffff_ffff, 1'b1,
        deque_result(32'h0, 32'h0, 32'h0, 1'b1, 7'd0, ST_POP_EMPTY)},
      '{REQ_PUSH_RIGHT, 32'ha5a5_a5a5, 1'b0, '0},
      '{REQ_PUSH_RIGHT, 32'h5a5a_5a5a, 1'b0, '0},
      '{REQ_PUSH_RIGHT, 32'h8000_0000, 1'b0, '0},
      '{REQ_PUSH_RIGHT, 32'h0000_0001, 1'b0, '0},
      '{REQ_PEEK,       32'hffff_ffff, 1'b0, '0},
      '{REQ_POP_LEFT,   32'h0000_0000, 1'b0, '0},
      '{REQ_POP_RIGHT,  32'h0000_0000, 1'b0, '0},
      '{REQ_PUSH_RIGHT, 32'h7fff_ffff, 1'b0, '0},
      '{REQ_POP_LEFT,   32'h0000_0000, 1'b0, '0},
      '{REQ_POP_RIGHT,  32'h0000_0000, 1'b0, '0},
      '{REQ_POP_RIGHT,  32'h0000_0000, 1'b0, '0},
      '{REQ_POP_LEFT,   32'h0000_0000, 1'b0, '0},
      '{REQ_PEEK,       32'h0000_0000, 1'b0, '0},
      '{REQ_PUSH_RIGHT, 32'h1234_5678, 1'b0, '0},
      '{REQ_POP_RIGHT,  32'h0000_0000, 1'b0, '0}
    };

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tbl[i]) begin
      item.req_type   = dir_tbl[i].op;
      item.item_value = dir_tbl[i].value;
      send_request(item, dir_tbl[i].typed, dir_tbl[i].result);
      maybe_idle(30);
    end
    hold_until_drained();

    // fill, drain and wander segments so both ends wrap and both refusals recur
    seg = 0;
    for (int phase = 0; phase < 3; phase++) begin
      for (int k = 0; k < RAND_PER_PHASE; k++) begin
        item.req_type   = pick_request((seg / SEG_LEN) % 3);
        item.item_value = pick_value();
        send_request(item, 1'b0, '0);
        seg++;
        maybe_idle(idle_pct[phase]);
      end
      hold_until_drained();
    end

    repeat (4) @(posedge clk);
    $display("%0d requests sent, %0d results checked", beats_sent, results_checked);
    $display("push-on-full refusals %0d, pop-on-empty refusals %0d",
             full_refusals, empty_refusals);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: files.f
design/dq_pkg.sv
design/dq_ram.sv
design/double_ended_queue.sv
dv/double_ended_queue_tb.sv
